@@ hw/rtl/fut_pkg.sv @@
// Package: shared types, codes and hex helpers for the form-urlencoded tokenizer.
`default_nettype none
package fut_pkg;

  localparam int unsigned MAX_RES = 4;
  localparam int unsigned CNT_W   = 3;   // holds 0..MAX_RES
  localparam int unsigned IDX_W   = 2;   // indexes MAX_RES entries

  localparam logic [7:0] CH_AMP   = 8'h26;  // '&'
  localparam logic [7:0] CH_EQ    = 8'h3D;  // '='
  localparam logic [7:0] CH_PLUS  = 8'h2B;  // '+'
  localparam logic [7:0] CH_PCT   = 8'h25;  // '%'
  localparam logic [7:0] CH_SPACE = 8'h20;  // ' '

  localparam logic [1:0] KIND_NAME  = 2'd0;
  localparam logic [1:0] KIND_VALUE = 2'd1;
  localparam logic [1:0] KIND_EOP   = 2'd2;

  typedef enum logic [1:0] {
    ESC_NONE = 2'd0,
    ESC_PCT  = 2'd1,
    ESC_HEX  = 2'd2
  } esc_t;

  typedef struct packed {
    logic [7:0] data;
    logic [1:0] kind;
    logic       done;
  } res_t;

  typedef struct packed {
    esc_t       esc;
    logic [7:0] first_hex;
    logic       in_value;
  } tok_state_t;

  typedef struct packed {
    logic [CNT_W-1:0]        cnt;
    res_t [MAX_RES-1:0]      res;
    tok_state_t              nxt;
  } dec_t;

  function automatic logic is_hex(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
           (c >= 8'h41 && c <= 8'h46);
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] v;
    v = 8'h00;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = c - 8'h30;
    end else if (c >= 8'h61 && c <= 8'h66) begin
      v = c - 8'h57;
    end else if (c >= 8'h41 && c <= 8'h46) begin
      v = c - 8'h37;
    end
    return v[3:0];
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/fut_if.sv @@
// Interfaces: input byte channel and result channel with valid/ready handshake.
`default_nettype none
interface fut_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_data;

  modport source (output valid, output in_byte, output end_of_data, input ready);
  modport sink   (input valid, input in_byte, input end_of_data, output ready);
endinterface

interface fut_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] kind;
  logic       last_of_run;
  logic       data_done;

  modport source (output valid, output out_byte, output kind, output last_of_run,
                  output data_done, input ready);
  modport sink   (input valid, input out_byte, input kind, input last_of_run,
                  input data_done, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/fut_decode.sv @@
// Decoder: turns one raw byte plus current state into up to four results and next state.
`default_nettype none
module fut_decode (
  input  wire logic [7:0]          c,
  input  wire logic                eod,
  input  wire fut_pkg::tok_state_t cur,
  output fut_pkg::dec_t            dec
);

  function automatic fut_pkg::dec_t push(input fut_pkg::dec_t d, input logic [7:0] b,
                                         input logic [1:0] k, input logic dn);
    fut_pkg::dec_t r;
    r = d;
    if (d.cnt < fut_pkg::CNT_W'(fut_pkg::MAX_RES)) begin
      r.res[d.cnt[fut_pkg::IDX_W-1:0]].data = b;
      r.res[d.cnt[fut_pkg::IDX_W-1:0]].kind = k;
      r.res[d.cnt[fut_pkg::IDX_W-1:0]].done = dn;
      r.cnt = d.cnt + fut_pkg::CNT_W'(1);
    end
    return r;
  endfunction

  always_comb begin
    fut_pkg::dec_t d;
    logic          fresh;
    logic [1:0]    pk;
    d       = '0;
    d.nxt   = cur;
    fresh   = 1'b1;
    pk      = cur.in_value ? fut_pkg::KIND_VALUE : fut_pkg::KIND_NAME;

    // pending escape: complete it, or flush it literally
    case (cur.esc)
      fut_pkg::ESC_PCT: begin
        if (fut_pkg::is_hex(c)) begin
          d.nxt.esc       = fut_pkg::ESC_HEX;
          d.nxt.first_hex = c;
          fresh           = 1'b0;
        end else begin
          d = push(d, fut_pkg::CH_PCT, pk, 1'b0);
          d.nxt.esc       = fut_pkg::ESC_NONE;
          d.nxt.first_hex = 8'h00;
        end
      end
      fut_pkg::ESC_HEX: begin
        if (fut_pkg::is_hex(c)) begin
          d = push(d, {fut_pkg::hex_val(cur.first_hex), fut_pkg::hex_val(c)}, pk, 1'b0);
          fresh = 1'b0;
        end else begin
          d = push(d, fut_pkg::CH_PCT, pk, 1'b0);
          d = push(d, cur.first_hex, pk, 1'b0);
        end
        d.nxt.esc       = fut_pkg::ESC_NONE;
        d.nxt.first_hex = 8'h00;
      end
      default: ;
    endcase

    if (fresh) begin
      if (c == fut_pkg::CH_PCT) begin
        d.nxt.esc = fut_pkg::ESC_PCT;
      end else if (c == fut_pkg::CH_PLUS) begin
        d = push(d, fut_pkg::CH_SPACE, pk, 1'b0);
      end else if (c == fut_pkg::CH_AMP) begin
        d = push(d, 8'h00, fut_pkg::KIND_EOP, 1'b0);
        d.nxt.in_value = 1'b0;
      end else if (c == fut_pkg::CH_EQ && !cur.in_value) begin
        d.nxt.in_value = 1'b1;
      end else begin
        d = push(d, c, pk, 1'b0);
      end
    end

    // end of data: flush what is left, close the pair, back to reset state
    if (eod) begin
      pk = d.nxt.in_value ? fut_pkg::KIND_VALUE : fut_pkg::KIND_NAME;
      if (d.nxt.esc == fut_pkg::ESC_PCT) begin
        d = push(d, fut_pkg::CH_PCT, pk, 1'b0);
      end else if (d.nxt.esc == fut_pkg::ESC_HEX) begin
        d = push(d, fut_pkg::CH_PCT, pk, 1'b0);
        d = push(d, d.nxt.first_hex, pk, 1'b0);
      end
      d = push(d, 8'h00, fut_pkg::KIND_EOP, 1'b1);
      d.nxt.esc       = fut_pkg::ESC_NONE;
      d.nxt.first_hex = 8'h00;
      d.nxt.in_value  = 1'b0;
    end

    dec = d;
  end

endmodule
`default_nettype wire

@@ hw/rtl/form_urlencoded_tokenizer.sv @@
// Top level: streaming form-urlencoded tokenizer with percent decoding.
//
// Channels: in_ch takes one raw byte per item (in_byte, end_of_data); out_ch
// gives decoded items (out_byte, kind, last_of_run, data_done). Both use a
// valid/ready handshake; an item moves when valid and ready are high at a
// rising clk edge.
// Each accepted byte is decoded in the accept cycle into 0 to 4 results,
// which land in a 4-entry result register. Results leave one per cycle while
// out_ch.ready is high, the first in the cycle after the byte was accepted.
// Throughput: one byte per cycle while each byte yields at most one result
// and out_ch.ready is high. A byte with several results (flushed escapes,
// end of data) holds the output while the result register drains; the drain
// sets the rate. The next byte is taken in the cycle the last pending result is taken.
// Bytes that yield no result ('%', a first hex digit, a first '=') pass
// through without using an output cycle.
// Reset (rst_n low, synchronous): escape state cleared, name part selected,
// result register emptied.
// Receiver stall: results hold in the result register and in_ch.ready stays
// low until the last one of the run is taken; no item is dropped.
`default_nettype none
module form_urlencoded_tokenizer (
  input  wire logic   clk,
  input  wire logic   rst_n,
  fut_in_if.sink      in_ch,
  fut_out_if.source   out_ch
);

  fut_pkg::tok_state_t                     st_r, st_nxt;
  fut_pkg::res_t [fut_pkg::MAX_RES-1:0]    buf_r, buf_nxt;
  logic [fut_pkg::CNT_W-1:0]               rem_r, rem_nxt;   // results still to send
  logic [fut_pkg::IDX_W-1:0]               hd_r, hd_nxt;     // entry now on the output
  fut_pkg::dec_t                           dec;
  logic                                    in_fire, out_fire;

  fut_decode u_dec (
    .c   (in_ch.in_byte),
    .eod (in_ch.end_of_data),
    .cur (st_r),
    .dec (dec)
  );

  // take a byte when the result register is empty or its last entry leaves now
  assign in_ch.ready = (rem_r == fut_pkg::CNT_W'(0)) ||
                       (rem_r == fut_pkg::CNT_W'(1) && out_ch.ready);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_fire    = out_ch.valid && out_ch.ready;

  assign out_ch.valid       = (rem_r != fut_pkg::CNT_W'(0));
  assign out_ch.out_byte    = buf_r[hd_r].data;
  assign out_ch.kind        = buf_r[hd_r].kind;
  assign out_ch.data_done   = buf_r[hd_r].done;
  assign out_ch.last_of_run = (rem_r == fut_pkg::CNT_W'(1));

  always_comb begin
    st_nxt  = st_r;
    buf_nxt = buf_r;
    rem_nxt = rem_r;
    hd_nxt  = hd_r;
    if (out_fire) begin
      rem_nxt = rem_r - fut_pkg::CNT_W'(1);
      hd_nxt  = hd_r + fut_pkg::IDX_W'(1);
    end
    if (in_fire) begin
      st_nxt  = dec.nxt;
      buf_nxt = dec.res;
      rem_nxt = dec.cnt;
      hd_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.esc       <= fut_pkg::ESC_NONE;
      st_r.first_hex <= 8'h00;
      st_r.in_value  <= 1'b0;
      rem_r          <= '0;
      hd_r           <= '0;
    end else begin
      st_r  <= st_nxt;
      rem_r <= rem_nxt;
      hd_r  <= hd_nxt;
    end
  end

  // payload only, no reset
  always_ff @(posedge clk) begin
    buf_r <= buf_nxt;
  end

endmodule
`default_nettype wire
